// ===== rtl/core/esg_pkg.sv =====
package esg_pkg;

    localparam int COORD_BITS = 12;
    localparam int CFG_W      = 12;
    localparam int MAG_W      = (COORD_BITS > CFG_W) ? COORD_BITS : CFG_W;
    localparam int QUO_W      = 10;
    localparam int NUM_W      = COORD_BITS + QUO_W;
    localparam int CNT_W      = $clog2(QUO_W);
    localparam int TRI_W      = COORD_BITS + 5;
    localparam int PROG_W     = 9;
    localparam int IN_W       = ((2 * COORD_BITS + 1 + 7) / 8) * 8;
    localparam int OUT_W      = 24;
    localparam int IDX_W      = 3;
    localparam int CMD_W      = 2;
    localparam int STATE_W    = 3;
    localparam int DIR_W      = 3;

    localparam logic [PROG_W-1:0] PROG_FULL = 9'd256;

    localparam logic [CMD_W-1:0] CMD_PRESS   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_MOVE    = 2'd1;
    localparam logic [CMD_W-1:0] CMD_RELEASE = 2'd2;

    localparam logic [STATE_W-1:0] GS_IDLE      = 3'd0;
    localparam logic [STATE_W-1:0] GS_STARTED   = 3'd1;
    localparam logic [STATE_W-1:0] GS_ACTIVE    = 3'd2;
    localparam logic [STATE_W-1:0] GS_COMPLETED = 3'd3;
    localparam logic [STATE_W-1:0] GS_CANCELLED = 3'd4;

    localparam logic [DIR_W-1:0] DIR_NONE  = 3'd0;
    localparam logic [DIR_W-1:0] DIR_LEFT  = 3'd1;
    localparam logic [DIR_W-1:0] DIR_RIGHT = 3'd2;
    localparam logic [DIR_W-1:0] DIR_UP    = 3'd3;
    localparam logic [DIR_W-1:0] DIR_DOWN  = 3'd4;

    localparam logic [IDX_W-1:0] REG_ENABLE    = 3'd0;
    localparam logic [IDX_W-1:0] REG_EDGE_ZONE = 3'd1;
    localparam logic [IDX_W-1:0] REG_MIN_DIST  = 3'd2;
    localparam logic [IDX_W-1:0] REG_MAX_DEV   = 3'd3;
    localparam logic [IDX_W-1:0] REG_FEEDBACK  = 3'd4;
    localparam logic [IDX_W-1:0] REG_SCREEN_W  = 3'd5;

    localparam logic [CFG_W-1:0] EDGE_MIN     = 12'd10;
    localparam logic [CFG_W-1:0] MIN_DIST_MIN = 12'd20;
    localparam logic [CFG_W-1:0] MAX_DEV_MIN  = 12'd10;
    localparam logic [CFG_W-1:0] SCREEN_MIN   = 12'd1;

    typedef struct packed {
        logic             enable;
        logic [CFG_W-1:0] edge_zone;
        logic [CFG_W-1:0] min_dist;
        logic [CFG_W-1:0] max_dev;
        logic             feedback;
        logic [CFG_W-1:0] screen_w;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        enable:    1'b1,
        edge_zone: 12'd50,
        min_dist:  12'd100,
        max_dev:   12'd50,
        feedback:  1'b1,
        screen_w:  12'd800
    };

    typedef struct packed {
        logic [DIR_W-1:0]      dir;
        logic                  swipe_ok;
        logic                  tenth_low;
        logic                  half_ok;
        logic [COORD_BITS-1:0] dx_pos_mag;
    } eval_t;

    typedef struct packed {
        logic               last;
        logic               consumed;
        logic               back_gesture;
        logic [DIR_W-1:0]   direction;
        logic               swipe_found;
        logic [PROG_W-1:0]  progress_q8;
        logic [STATE_W-1:0] new_state;
        logic               notify;
    } res_t;

endpackage

// ===== rtl/core/esg_eval.sv =====
module esg_eval (
    input  logic [esg_pkg::COORD_BITS-1:0] cur_x,
    input  logic [esg_pkg::COORD_BITS-1:0] cur_y,
    input  logic [esg_pkg::COORD_BITS-1:0] org_x,
    input  logic [esg_pkg::COORD_BITS-1:0] org_y,
    input  esg_pkg::cfg_t                  cfg,
    output esg_pkg::eval_t                 ev
);
    import esg_pkg::*;

    logic signed [COORD_BITS:0] dx;
    logic signed [COORD_BITS:0] dy;
    logic [COORD_BITS-1:0]      ax;
    logic [COORD_BITS-1:0]      ay;
    logic                       dx_pos;
    logic                       dy_pos;
    logic [TRI_W-1:0]           dx30;
    logic [TRI_W-1:0]           dx6;
    logic                       valid;

    always_comb
    begin
        dx     = $signed({1'b0, cur_x}) - $signed({1'b0, org_x});
        dy     = $signed({1'b0, cur_y}) - $signed({1'b0, org_y});
        ax     = dx[COORD_BITS] ? COORD_BITS'(-dx) : dx[COORD_BITS-1:0];
        ay     = dy[COORD_BITS] ? COORD_BITS'(-dy) : dy[COORD_BITS-1:0];
        dx_pos = !dx[COORD_BITS] && (dx != '0);
        dy_pos = !dy[COORD_BITS] && (dy != '0);

        if ((MAG_W'(ax) < MAG_W'(cfg.min_dist)) && (MAG_W'(ay) < MAG_W'(cfg.min_dist)))
        begin
            ev.dir = DIR_NONE;
        end
        else if (ax > ay)
        begin
            ev.dir = dx_pos ? DIR_RIGHT : DIR_LEFT;
        end
        else
        begin
            ev.dir = dy_pos ? DIR_DOWN : DIR_UP;
        end

        // horizontal swipes only count toward the right
        if (ev.dir == DIR_LEFT || ev.dir == DIR_RIGHT)
        begin
            valid = (MAG_W'(ay) <= MAG_W'(cfg.max_dev)) && dx_pos;
        end
        else
        begin
            valid = MAG_W'(ax) <= MAG_W'(cfg.max_dev);
        end
        ev.swipe_ok = (ev.dir != DIR_NONE) && valid;

        dx30         = TRI_W'(ax) * TRI_W'(30);
        dx6          = TRI_W'(ax) * TRI_W'(6);
        ev.tenth_low = !dx_pos || (dx30 < TRI_W'(cfg.screen_w));
        ev.half_ok   = dx_pos && (dx6 >= TRI_W'(cfg.screen_w));
        ev.dx_pos_mag = dx_pos ? ax : '0;
    end

endmodule

// ===== rtl/core/esg_div.sv =====
module esg_div (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [esg_pkg::COORD_BITS-1:0] dx,
    input  logic [esg_pkg::CFG_W-1:0]      divisor,
    output logic                           done,
    output logic [esg_pkg::PROG_W-1:0]     quotient
);
    import esg_pkg::*;

    logic             run_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [CFG_W-1:0] rem_reg;
    logic [QUO_W-1:0] lo_reg;
    logic [QUO_W-1:0] q_reg;
    logic             sat_reg;

    logic [NUM_W-1:0]      num;
    logic [COORD_BITS-1:0] hi;
    logic                  hi_sat;
    logic [CFG_W:0]        trial;
    logic                  ge;
    logic [CFG_W:0]        diff;

    always_comb
    begin
        // 768 * dx; the top bits decide whether the quotient already exceeds 10 bits
        num    = (NUM_W'(dx) << 9) + (NUM_W'(dx) << 8);
        hi     = num[NUM_W-1:QUO_W];
        hi_sat = MAG_W'(hi) >= MAG_W'(divisor);
        trial  = {rem_reg, lo_reg[QUO_W-1]};
        ge     = trial >= {1'b0, divisor};
        diff   = trial - {1'b0, divisor};
    end

    assign done = run_reg && (cnt_reg == '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg <= 1'b0;
            cnt_reg <= '0;
            rem_reg <= '0;
            lo_reg  <= '0;
            q_reg   <= '0;
            sat_reg <= 1'b0;
        end
        else if (start)
        begin
            run_reg <= 1'b1;
            cnt_reg <= CNT_W'(QUO_W - 1);
            rem_reg <= hi_sat ? '0 : CFG_W'(hi);
            lo_reg  <= num[QUO_W-1:0];
            q_reg   <= '0;
            sat_reg <= hi_sat;
        end
        else if (run_reg)
        begin
            rem_reg <= ge ? diff[CFG_W-1:0] : trial[CFG_W-1:0];
            lo_reg  <= {lo_reg[QUO_W-2:0], 1'b0};
            q_reg   <= {q_reg[QUO_W-2:0], ge};
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                run_reg <= 1'b0;
            end
        end
    end

    always_comb
    begin
        if (sat_reg || q_reg[QUO_W-1] || (q_reg[PROG_W-1] && (q_reg[PROG_W-2:0] != '0)))
        begin
            quotient = PROG_FULL;
        end
        else
        begin
            quotient = q_reg[PROG_W-1:0];
        end
    end

endmodule

// ===== rtl/core/edge_swipe_gesture_detector.sv =====
// Left-edge swipe recognizer for a pointer event stream.
// Slave stream: one pointer event per transaction; s_tuser is the event kind
// (press, move, release), s_tdata carries the coordinates and point-present flag.
// Master stream: one result per event, two for the release of an active gesture
// (state result with tlast low, then the return-to-idle result with tlast high).
// Config channel: cfg_index selects the register, cfg_data is the value; always
// ready, takes effect at once and should only be written while the block is idle.
// Sequencing: one event at a time. Press, release and ignored events pass from
// accept through evaluate to emit, and the next event is taken once the result
// is loaded; a move during a gesture also passes through divider start, divide
// and move finish before emit, the divide being done by the 10-step restoring
// divider that forms progress = 768 * dx / screen_width.
// A release stays in emit until its second result is loaded.
// s_tready is high only between events. The result register frees the sequencer
// as soon as it is loaded; if m_tready stays low the block waits before loading
// the next result, so nothing is dropped.
// Reset: all registers but the captured event take their default values,
// gesture state is idle, no gesture is active and no result is pending.
module edge_swipe_gesture_detector (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [esg_pkg::IN_W-1:0]    s_tdata,   // pos_x, pos_y, point_ok, zero pad
    input  logic [esg_pkg::CMD_W-1:0]   s_tuser,   // cmd
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [esg_pkg::OUT_W-1:0]   m_tdata,   // notify, new_state, progress_q8,
                                                   // swipe_found, direction,
                                                   // back_gesture, consumed, zero pad
    output logic                        m_tlast,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [esg_pkg::IDX_W-1:0]   cfg_index,
    input  logic [esg_pkg::CFG_W-1:0]   cfg_data
);
    import esg_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_EVAL   = 3'd1;
    localparam logic [2:0] S_DSTART = 3'd2;
    localparam logic [2:0] S_DIV    = 3'd3;
    localparam logic [2:0] S_MFIN   = 3'd4;
    localparam logic [2:0] S_EMIT   = 3'd5;

    logic [2:0] st_reg;
    logic [2:0] st_next;

    cfg_t cfg_reg;

    logic [CMD_W-1:0]      cmd_reg;
    logic [COORD_BITS-1:0] px_reg;
    logic [COORD_BITS-1:0] py_reg;
    logic                  ok_reg;

    logic                  active_reg;
    logic [COORD_BITS-1:0] sx_reg;
    logic [COORD_BITS-1:0] sy_reg;
    logic [COORD_BITS-1:0] cx_reg;
    logic [COORD_BITS-1:0] cy_reg;
    logic [STATE_W-1:0]    gst_reg;

    res_t res_reg;
    res_t out_reg;
    logic pend_reg;
    logic out_valid_reg;

    eval_t              ev;
    logic               div_done;
    logic [PROG_W-1:0]  div_q;
    logic               out_free;
    logic               move_go;
    logic [STATE_W-1:0] mv_target;
    logic [STATE_W-1:0] rl_target;

    esg_eval u_eval (
        .cur_x (cx_reg),
        .cur_y (cy_reg),
        .org_x (sx_reg),
        .org_y (sy_reg),
        .cfg   (cfg_reg),
        .ev    (ev)
    );

    esg_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (st_reg == S_DSTART),
        .dx       (ev.dx_pos_mag),
        .divisor  (cfg_reg.screen_w),
        .done     (div_done),
        .quotient (div_q)
    );

    assign s_tready  = (st_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = {(OUT_W - $bits(res_t) + 1)'(0), out_reg[$bits(res_t)-2:0]};
    assign m_tlast   = out_reg.last;
    assign out_free  = !out_valid_reg || m_tready;

    always_comb
    begin
        move_go = cfg_reg.enable && (cmd_reg == CMD_MOVE) && ok_reg && active_reg;

        if (ev.swipe_ok)
        begin
            mv_target = GS_ACTIVE;
        end
        else if (ev.tenth_low)
        begin
            mv_target = GS_STARTED;
        end
        else
        begin
            mv_target = GS_CANCELLED;
        end

        rl_target = (ev.swipe_ok && ev.half_ok) ? GS_COMPLETED : GS_CANCELLED;
    end

    always_comb
    begin
        st_next = st_reg;
        unique case (st_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    st_next = S_EVAL;
                end
            end
            S_EVAL:   st_next = move_go ? S_DSTART : S_EMIT;
            S_DSTART: st_next = S_DIV;
            S_DIV:
            begin
                if (div_done)
                begin
                    st_next = S_MFIN;
                end
            end
            S_MFIN:   st_next = S_EMIT;
            S_EMIT:
            begin
                if (out_free && !pend_reg)
                begin
                    st_next = S_IDLE;
                end
            end
            default:  st_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            cmd_reg <= s_tuser;
            px_reg  <= s_tdata[COORD_BITS-1:0];
            py_reg  <= s_tdata[2*COORD_BITS-1:COORD_BITS];
            ok_reg  <= s_tdata[2*COORD_BITS];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg        <= S_IDLE;
            cfg_reg       <= CFG_RESET;
            active_reg    <= 1'b0;
            sx_reg        <= '0;
            sy_reg        <= '0;
            cx_reg        <= '0;
            cy_reg        <= '0;
            gst_reg       <= GS_IDLE;
            res_reg       <= '0;
            out_reg       <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            st_reg <= st_next;

            if (cfg_valid)
            begin
                unique case (cfg_index)
                    REG_ENABLE:
                    begin
                        cfg_reg.enable <= cfg_data[0];
                        if (!cfg_data[0])
                        begin
                            active_reg <= 1'b0;
                            sx_reg     <= '0;
                            sy_reg     <= '0;
                            cx_reg     <= '0;
                            cy_reg     <= '0;
                            gst_reg    <= GS_IDLE;
                        end
                    end
                    REG_EDGE_ZONE:
                        cfg_reg.edge_zone <= (cfg_data < EDGE_MIN) ? EDGE_MIN : cfg_data;
                    REG_MIN_DIST:
                        cfg_reg.min_dist <= (cfg_data < MIN_DIST_MIN) ? MIN_DIST_MIN : cfg_data;
                    REG_MAX_DEV:
                        cfg_reg.max_dev <= (cfg_data < MAX_DEV_MIN) ? MAX_DEV_MIN : cfg_data;
                    REG_FEEDBACK:
                        cfg_reg.feedback <= cfg_data[0];
                    REG_SCREEN_W:
                        cfg_reg.screen_w <= (cfg_data < SCREEN_MIN) ? SCREEN_MIN : cfg_data;
                    default:
                    begin
                    end
                endcase
            end

            if (m_tvalid && m_tready)
            begin
                out_valid_reg <= 1'b0;
            end

            case (st_reg)
                S_EVAL:
                begin
                    // default: no state change, single result
                    res_reg             <= '0;
                    res_reg.new_state   <= gst_reg;
                    res_reg.last        <= 1'b1;
                    if (cfg_reg.enable)
                    begin
                        case (cmd_reg)
                            CMD_PRESS:
                            begin
                                if (ok_reg && (MAG_W'(px_reg) <= MAG_W'(cfg_reg.edge_zone)))
                                begin
                                    sx_reg            <= px_reg;
                                    sy_reg            <= py_reg;
                                    cx_reg            <= px_reg;
                                    cy_reg            <= py_reg;
                                    active_reg        <= 1'b1;
                                    gst_reg           <= GS_STARTED;
                                    res_reg.new_state <= GS_STARTED;
                                    res_reg.notify    <= (gst_reg != GS_STARTED) &&
                                                         cfg_reg.feedback;
                                end
                            end
                            CMD_MOVE:
                            begin
                                res_reg.consumed <= active_reg;
                                if (move_go)
                                begin
                                    cx_reg <= px_reg;
                                    cy_reg <= py_reg;
                                end
                            end
                            CMD_RELEASE:
                            begin
                                if (ok_reg && active_reg)
                                begin
                                    res_reg.new_state <= rl_target;
                                    res_reg.notify    <= (gst_reg != rl_target) &&
                                                         cfg_reg.feedback;
                                    res_reg.last      <= 1'b0;
                                    if (rl_target == GS_COMPLETED)
                                    begin
                                        res_reg.progress_q8  <= PROG_FULL;
                                        res_reg.swipe_found  <= 1'b1;
                                        res_reg.direction    <= ev.dir;
                                        res_reg.back_gesture <= (ev.dir == DIR_RIGHT);
                                    end
                                    // the gesture ends here; the idle result follows
                                    active_reg <= 1'b0;
                                    sx_reg     <= '0;
                                    sy_reg     <= '0;
                                    cx_reg     <= '0;
                                    cy_reg     <= '0;
                                    gst_reg    <= GS_IDLE;
                                    pend_reg   <= 1'b1;
                                end
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                end
                S_MFIN:
                begin
                    gst_reg             <= mv_target;
                    res_reg             <= '0;
                    res_reg.new_state   <= mv_target;
                    res_reg.notify      <= (gst_reg != mv_target) && cfg_reg.feedback;
                    res_reg.progress_q8 <= (mv_target == GS_CANCELLED) ? '0 : div_q;
                    res_reg.consumed    <= 1'b1;
                    res_reg.last        <= 1'b1;
                end
                S_EMIT:
                begin
                    if (out_free)
                    begin
                        out_reg       <= res_reg;
                        out_valid_reg <= 1'b1;
                        if (pend_reg)
                        begin
                            res_reg           <= '0;
                            res_reg.new_state <= GS_IDLE;
                            res_reg.notify    <= cfg_reg.feedback;
                            res_reg.last      <= 1'b1;
                            pend_reg          <= 1'b0;
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    a_idle_when_inactive: assert property (@(posedge clk) disable iff (!rst_n)
        !active_reg |-> gst_reg == GS_IDLE)
        else $error("gesture state not idle without an active gesture");

    a_found_completes: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_reg.swipe_found |->
            out_reg.new_state == GS_COMPLETED && !out_reg.last)
        else $error("swipe_found on a result that is not a completion");

    a_progress_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> out_reg.progress_q8 <= PROG_FULL)
        else $error("progress above full scale");

    a_pend_in_emit: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg |-> st_reg == S_EMIT)
        else $error("second release result pending outside emit");

    a_div_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg == S_DSTART) |=> st_reg == S_DIV && !div_done)
        else $error("divider finished too early");

endmodule

// ===== bench/tb_edge_swipe_gesture_detector.sv =====
module tb_edge_swipe_gesture_detector;
    import esg_pkg::*;

    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
    localparam logic [IDX_W-1:0] REG_UNUSED = 3'd7;
    localparam int COORD_MAX     = (1 << COORD_BITS) - 1;
    localparam int SETTLE_CYCLES = 20;
    localparam int LONG_STALL    = 300;

    typedef struct {
        logic [CMD_W-1:0]      cmd;
        logic [COORD_BITS-1:0] x;
        logic [COORD_BITS-1:0] y;
        logic                  ok;
        bit                    hold_for_drain;   // offer only once all results are back
    } ptr_event_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               s_tvalid = 1'b0;
    logic               s_tready;
    logic [IN_W-1:0]    s_tdata = '0;    // pos_x, pos_y, point_ok, zero pad
    logic [CMD_W-1:0]   s_tuser = '0;    // cmd
    logic               m_tvalid;
    logic               m_tready = 1'b0;
    logic [OUT_W-1:0]   m_tdata;         // notify, new_state, progress_q8, swipe_found,
                                         // direction, back_gesture, consumed, zero pad
    logic               m_tlast;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [IDX_W-1:0]   cfg_index = '0;
    logic [CFG_W-1:0]   cfg_data = '0;

    ptr_event_t pending_ptrs[$];
    res_t       due_results[$];
    ptr_event_t offered;

    int mismatches = 0;
    int n_queued = 0;
    int send_idle_pct = 9;
    int recv_idle_pct = 61;
    int stall_reqs = 0;
    int stall_taken = 0;
    int stall_left = 0;

    // gesture tracker state
    cfg_t                 cfg;
    bit                   g_active;
    int                   sx, sy, cx, cy;
    logic [STATE_W-1:0]   g_state;

    edge_swipe_gesture_detector DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic void clear_gesture();
        g_active = 1'b0;
        sx = 0;
        sy = 0;
        cx = 0;
        cy = 0;
        g_state = GS_IDLE;
    endfunction

    function automatic logic [DIR_W-1:0] swipe_dir();
        int dx, dy, ax, ay;
        dx = cx - sx;
        dy = cy - sy;
        ax = (dx < 0) ? -dx : dx;
        ay = (dy < 0) ? -dy : dy;
        if (ax < int'(cfg.min_dist) && ay < int'(cfg.min_dist))
            return DIR_NONE;
        if (ax > ay)
            return (dx > 0) ? DIR_RIGHT : DIR_LEFT;
        return (dy > 0) ? DIR_DOWN : DIR_UP;
    endfunction

    // horizontal swipes only count when moving right
    function automatic bit swipe_ok(logic [DIR_W-1:0] d);
        int dx, dy;
        dx = cx - sx;
        dy = cy - sy;
        if (d == DIR_LEFT || d == DIR_RIGHT)
            return ((dy < 0) ? -dy : dy) <= int'(cfg.max_dev) && dx > 0;
        if (d == DIR_UP || d == DIR_DOWN)
            return ((dx < 0) ? -dx : dx) <= int'(cfg.max_dev);
        return 1'b0;
    endfunction

    function automatic bit move_to(logic [STATE_W-1:0] s);
        bit changed;
        changed = (g_state != s);
        g_state = s;
        return changed;
    endfunction

    function automatic void post_result(bit changed, int prog, bit found,
                                        logic [DIR_W-1:0] d, bit consumed, bit last_one);
        res_t r;
        r.notify       = changed && cfg.feedback;
        r.new_state    = g_state;
        r.progress_q8  = PROG_W'(prog);
        r.swipe_found  = found;
        r.direction    = d;
        r.back_gesture = found && d == DIR_RIGHT;
        r.consumed     = consumed;
        r.last         = last_one;
        due_results.push_back(r);
    endfunction

    function automatic void track_gesture(ptr_event_t ev);
        bit changed;
        int dx, prog;
        logic [DIR_W-1:0] d;
        if (!cfg.enable || ev.cmd == CMD_UNUSED) begin
            post_result(1'b0, 0, 1'b0, DIR_NONE, 1'b0, 1'b1);
            return;
        end
        case (ev.cmd)
            CMD_PRESS:
            begin
                changed = 1'b0;
                if (ev.ok && ev.x <= cfg.edge_zone) begin
                    sx = int'(ev.x);
                    sy = int'(ev.y);
                    cx = int'(ev.x);
                    cy = int'(ev.y);
                    g_active = 1'b1;
                    changed = move_to(GS_STARTED);
                end
                post_result(changed, 0, 1'b0, DIR_NONE, 1'b0, 1'b1);
            end
            CMD_MOVE:
            begin
                if (!ev.ok || !g_active) begin
                    post_result(1'b0, 0, 1'b0, DIR_NONE, g_active, 1'b1);
                    return;
                end
                cx = int'(ev.x);
                cy = int'(ev.y);
                dx = cx - sx;
                prog = (dx <= 0) ? 0 : (768 * dx) / int'(cfg.screen_w);
                if (prog > 256)
                    prog = 256;
                d = swipe_dir();
                if (d != DIR_NONE && swipe_ok(d))
                    changed = move_to(GS_ACTIVE);
                else if (dx <= 0 || 30 * dx < int'(cfg.screen_w))
                    changed = move_to(GS_STARTED);
                else begin
                    changed = move_to(GS_CANCELLED);
                    prog = 0;
                end
                post_result(changed, prog, 1'b0, DIR_NONE, 1'b1, 1'b1);
            end
            default:
            begin
                if (!ev.ok || !g_active) begin
                    post_result(1'b0, 0, 1'b0, DIR_NONE, 1'b0, 1'b1);
                    return;
                end
                dx = cx - sx;
                d = swipe_dir();
                if (d != DIR_NONE && swipe_ok(d) && dx > 0 && 6 * dx >= int'(cfg.screen_w)) begin
                    changed = move_to(GS_COMPLETED);
                    post_result(changed, PROG_FULL, 1'b1, d, 1'b0, 1'b0);
                end else begin
                    changed = move_to(GS_CANCELLED);
                    post_result(changed, 0, 1'b0, DIR_NONE, 1'b0, 1'b0);
                end
                // completed or cancelled always differs from idle
                clear_gesture();
                post_result(1'b1, 0, 1'b0, DIR_NONE, 1'b0, 1'b1);
            end
        endcase
    endfunction

    function automatic void apply_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] data);
        case (idx)
            REG_ENABLE:
            begin
                cfg.enable = data[0];
                if (!data[0])
                    clear_gesture();
            end
            REG_EDGE_ZONE: cfg.edge_zone = (data < EDGE_MIN) ? EDGE_MIN : data;
            REG_MIN_DIST:  cfg.min_dist = (data < MIN_DIST_MIN) ? MIN_DIST_MIN : data;
            REG_MAX_DEV:   cfg.max_dev = (data < MAX_DEV_MIN) ? MAX_DEV_MIN : data;
            REG_FEEDBACK:  cfg.feedback = data[0];
            REG_SCREEN_W:  cfg.screen_w = (data < SCREEN_MIN) ? SCREEN_MIN : data;
            default: ;
        endcase
    endfunction

    task automatic report_mismatch(string what, int got_v, int want_v);
        $display("%0t: %s mismatch: got %0d, expected %0d", $realtime, what, got_v, want_v);
        mismatches++;
    endtask

    task automatic write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] data);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        apply_reg(idx, data);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_all(bit en, int edge_w, int min_d, int dev, bit fb, int scr);
        write_reg(REG_ENABLE, CFG_W'(en));
        write_reg(REG_EDGE_ZONE, CFG_W'(edge_w));
        write_reg(REG_MIN_DIST, CFG_W'(min_d));
        write_reg(REG_MAX_DEV, CFG_W'(dev));
        write_reg(REG_FEEDBACK, CFG_W'(fb));
        write_reg(REG_SCREEN_W, CFG_W'(scr));
    endtask

    // mostly a small working range, sometimes anywhere in the register
    function automatic int rand_reg(int lo, int hi);
        if ($urandom_range(4) == 0)
            return $urandom_range(COORD_MAX);
        return $urandom_range(hi, lo);
    endfunction

    function automatic int to_coord(int v);
        if (v < 0)
            return 0;
        if (v > COORD_MAX)
            return COORD_MAX;
        return v;
    endfunction

    function automatic void queue_ptr(logic [CMD_W-1:0] cmd, int x, int y, bit ok);
        ptr_event_t ev;
        ev.cmd = cmd;
        ev.x = COORD_BITS'(x);
        ev.y = COORD_BITS'(y);
        ev.ok = ok;
        ev.hold_for_drain = ($urandom_range(99) == 0);
        pending_ptrs.push_back(ev);
        n_queued++;
    endfunction

    // press in the zone, a few moves around the start point, usually a release
    function automatic void queue_swipe();
        int x0, y0, reach, drift, dx, dy, n;
        x0 = $urandom_range(int'(cfg.edge_zone));
        y0 = $urandom_range(COORD_MAX);
        queue_ptr(CMD_PRESS, x0, y0, $urandom_range(19) != 0);
        n = $urandom_range(5, 1);
        repeat (n)
        begin
            reach = $urandom_range(2 * int'(cfg.min_dist) + int'(cfg.screen_w) / 3);
            drift = $urandom_range(2 * int'(cfg.max_dev));
            if ($urandom_range(1))
                drift = -drift;
            case ($urandom_range(5))
                0, 1, 2:
                begin
                    dx = reach;
                    dy = drift;
                end
                3:
                begin
                    dx = -reach;
                    dy = drift;
                end
                4:
                begin
                    dx = drift;
                    dy = reach;
                end
                default:
                begin
                    dx = drift;
                    dy = -reach;
                end
            endcase
            queue_ptr(CMD_MOVE, to_coord(x0 + dx), to_coord(y0 + dy), $urandom_range(19) != 0);
        end
        if ($urandom_range(9) != 0)
            queue_ptr(CMD_RELEASE, $urandom_range(COORD_MAX), $urandom_range(COORD_MAX),
                      $urandom_range(19) != 0);
    endfunction

    function automatic void queue_mix(int count);
        int stop_at;
        stop_at = n_queued + count;
        while (n_queued < stop_at)
        begin
            if ($urandom_range(4) != 0)
                queue_swipe();
            else
                queue_ptr(CMD_W'($urandom_range(3)), $urandom_range(COORD_MAX),
                          $urandom_range(COORD_MAX), 1'($urandom_range(1)));
        end
    endfunction

    task automatic wait_idle();
        do
            @(negedge clk);
        while (pending_ptrs.size() != 0 || s_tvalid || due_results.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // sender: holds each offer until the transaction completes
    always @(posedge clk)
    begin : drive_events
        logic [IN_W-1:0] word;
        bit busy;
        if (rst_n) begin
            busy = s_tvalid;
            if (s_tvalid && s_tready) begin
                track_gesture(offered);
                busy = 1'b0;
            end
            if (!busy) begin
                if (pending_ptrs.size() != 0 && $urandom_range(99) >= send_idle_pct
                    && !(pending_ptrs[0].hold_for_drain && due_results.size() != 0)) begin
                    offered = pending_ptrs.pop_front();
                    word = '0;
                    word[COORD_BITS-1:0] = offered.x;
                    word[2*COORD_BITS-1:COORD_BITS] = offered.y;
                    word[2*COORD_BITS] = offered.ok;
                    s_tdata  <= word;
                    s_tuser  <= offered.cmd;
                    s_tvalid <= 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk)
    begin : drive_ready
        if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            m_tready   <= 1'b0;
        end else if (stall_taken != stall_reqs) begin
            stall_taken <= stall_taken + 1;
            stall_left  <= LONG_STALL;
            m_tready    <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin : check_results
        res_t got, want;
        if (rst_n && m_tvalid && m_tready) begin
            got = {m_tlast, m_tdata[$bits(res_t)-2:0]};
            if (due_results.size() == 0) begin
                report_mismatch("unexpected result", 1, 0);
            end else begin
                want = due_results.pop_front();
                if (got.notify != want.notify)
                    report_mismatch("notify", got.notify, want.notify);
                if (got.new_state != want.new_state)
                    report_mismatch("new_state", got.new_state, want.new_state);
                if (got.progress_q8 != want.progress_q8)
                    report_mismatch("progress_q8", got.progress_q8, want.progress_q8);
                if (got.swipe_found != want.swipe_found)
                    report_mismatch("swipe_found", got.swipe_found, want.swipe_found);
                if (got.direction != want.direction)
                    report_mismatch("direction", got.direction, want.direction);
                if (got.back_gesture != want.back_gesture)
                    report_mismatch("back_gesture", got.back_gesture, want.back_gesture);
                if (got.consumed != want.consumed)
                    report_mismatch("consumed", got.consumed, want.consumed);
                if (got.last != want.last)
                    report_mismatch("tlast", got.last, want.last);
            end
        end
    end

    initial
    begin
        int ph;
        cfg = CFG_RESET;
        clear_gesture();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset settings: zone 50, distance 100, deviation 50, width 800
        queue_ptr(CMD_MOVE, COORD_MAX, COORD_MAX, 1'b1);   // no gesture yet
        queue_ptr(CMD_RELEASE, 0, 0, 1'b1);
        queue_ptr(CMD_UNUSED, COORD_MAX, 0, 1'b1);
        queue_ptr(CMD_PRESS, 51, 0, 1'b1);                 // just outside the zone
        queue_ptr(CMD_PRESS, 50, COORD_MAX, 1'b0);         // no point
        queue_ptr(CMD_PRESS, 50, 2000, 1'b1);
        queue_ptr(CMD_PRESS, 0, 2000, 1'b1);               // restart, state unchanged
        queue_ptr(CMD_MOVE, 500, 2000, 1'b0);              // swallowed, nothing stored
        queue_ptr(CMD_MOVE, 10, 2000, 1'b1);
        queue_ptr(CMD_MOVE, 300, 2000, 1'b1);              // right, progress saturates
        queue_ptr(CMD_MOVE, 300, 2100, 1'b1);              // too much deviation: cancel
        queue_ptr(CMD_MOVE, 300, 2040, 1'b1);              // revived while still active
        queue_ptr(CMD_RELEASE, 0, 0, 1'b0);
        queue_ptr(CMD_RELEASE, COORD_MAX, COORD_MAX, 1'b1);
        queue_ptr(CMD_PRESS, 20, 100, 1'b1);
        queue_ptr(CMD_MOVE, 20, COORD_MAX, 1'b1);          // down
        queue_ptr(CMD_RELEASE, 0, 0, 1'b1);                // no dx: cancel then idle
        queue_ptr(CMD_PRESS, 10, 3000, 1'b1);
        queue_ptr(CMD_MOVE, 0, 3000, 1'b1);
        queue_ptr(CMD_MOVE, 0, 0, 1'b1);                   // up
        queue_ptr(CMD_MOVE, COORD_MAX, 0, 1'b1);
        queue_ptr(CMD_RELEASE, 0, 0, 1'b1);
        queue_ptr(CMD_PRESS, 0, 0, 1'b1);
        queue_ptr(CMD_MOVE, 150, 0, 1'b1);
        queue_ptr(CMD_RELEASE, 0, 0, 1'b1);                // just over half progress
        wait_idle();

        // every clamped field below its floor
        set_all(1'b1, 0, 0, 0, 1'b0, 0);
        @(negedge clk);
        queue_mix(40);
        queue_ptr(CMD_PRESS, 30, 0, 1'b1);
        queue_ptr(CMD_MOVE, 0, 0, 1'b1);                   // leftward
        queue_ptr(CMD_MOVE, 200, 0, 1'b1);                 // leaves the gesture active
        wait_idle();

        // disable with a gesture in flight, then a write to an unmapped index
        write_reg(REG_ENABLE, '0);
        write_reg(REG_UNUSED, '1);
        @(negedge clk);
        queue_mix(15);
        wait_idle();

        set_all(1'b1, COORD_MAX, COORD_MAX, COORD_MAX, 1'b1, COORD_MAX);
        @(negedge clk);
        queue_mix(40);
        wait_idle();

        for (ph = 0; ph < 12; ph++)
        begin
            set_all($urandom_range(9) != 0, rand_reg(10, 200), rand_reg(20, 400),
                    rand_reg(10, 150), 1'($urandom_range(1)), rand_reg(100, 1600));
            @(negedge clk);
            if (ph == 4) begin
                send_idle_pct = 61;
                recv_idle_pct = 9;
            end else if (ph == 8) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            queue_mix(125);
            if (ph == 1 || ph == 6 || ph == 9)
                stall_reqs++;
            wait_idle();
        end

        if (mismatches == 0 && due_results.size() == 0)
            $display("edge_swipe_gesture_detector test passed");
        else
            $display("edge_swipe_gesture_detector test failed");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("edge_swipe_gesture_detector test failed");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/esg_pkg.sv
rtl/core/esg_eval.sv
rtl/core/esg_div.sv
rtl/core/edge_swipe_gesture_detector.sv
bench/tb_edge_swipe_gesture_detector.sv
